/* src/rbat_pkg.sv */
// rbat_pkg: widths, command/status codes, register indexes and the
// controller/datapath command and status structs of the block allocator table.
// No dependencies.
package rbat_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int ADDR_W          = 48;   // sector address width
	localparam int RND_W           = 63;
	localparam int SEG_W           = 16;
	localparam int CMD_W           = 3;
	localparam int ST_W            = 3;
	localparam int CNT_W           = 9;    // entry_count field
	localparam int SPB_W           = 17;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 48;
	localparam int WIDE_W          = 64;   // arithmetic unit word
	localparam int ARITH_CNT_W     = 6;

	// commands
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PICK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MARK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	// result status
	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [ST_W-1:0] ST_OCCUPIED = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;
	localparam logic [ST_W-1:0] ST_NOTREADY = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEV_SECTORS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPB         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_SECTORS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WHOLE_MODE  = 2'd3;

	// arithmetic unit operations
	localparam logic ARITH_DIV = 1'b0;
	localparam logic ARITH_MUL = 1'b1;

	// arithmetic operand sources
	localparam logic [2:0] SRC_SPAN_N  = 3'd0;  // span / n
	localparam logic [2:0] SRC_RND_DIV = 3'd1;  // rnd % quotient
	localparam logic [2:0] SRC_REM_N   = 3'd2;  // remainder * n
	localparam logic [2:0] SRC_SEG_SS  = 3'd3;  // segment * segment size
	localparam logic [2:0] SRC_RND_TOT = 3'd4;  // rnd % entry total

	// result address select
	localparam logic [1:0] RA_ZERO   = 2'd0;
	localparam logic [1:0] RA_SECTOR = 2'd1;
	localparam logic [1:0] RA_RDDATA = 2'd2;

	// memory write select
	localparam logic [1:0] WR_NEW  = 2'd0;
	localparam logic [1:0] WR_MARK = 2'd1;
	localparam logic [1:0] WR_MOVE = 2'd2;

	// memory read select
	localparam logic RD_LAST = 1'b0;
	localparam logic RD_PICK = 1'b1;

	// search key select
	localparam logic KEY_SECTOR = 1'b0;
	localparam logic KEY_BADDR  = 1'b1;

	typedef struct packed {
		logic            in_ready;
		logic            clear_total;
		logic            set_res;
		logic [ST_W-1:0] res_st;
		logic [1:0]      res_addr_sel;
		logic            ar_start;
		logic [2:0]      ar_src;
		logic            lat_off;
		logic            lat_base;
		logic            zero_base;
		logic            calc_sector;
		logic            srch_start;
		logic            srch_key_sel;
		logic            mem_wr;
		logic [1:0]      mem_wr_sel;
		logic            mem_rd;
		logic            mem_rd_sel;
		logic            inc_total;
		logic            dec_total;
		logic            out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic             req_valid;
		logic [CMD_W-1:0] cmd_code;
		logic             n_zero;
		logic             total_zero;
		logic             total_full;
		logic             whole_mode;
		logic             ar_done;
		logic             quo_zero;
		logic             range_fail;
		logic             srch_done;
		logic             srch_found;
		logic             rd_ready_bit;
		logic             out_busy;
	} dp_stat_t;

endpackage

/* src/rbat_req_if.sv */
// rbat_req_if: operation request channel (valid/ready plus item fields).
// Depends on rbat_pkg.
interface rbat_req_if;
	logic                           valid;
	logic                           ready;
	logic [rbat_pkg::CMD_W-1:0]     command;
	logic [rbat_pkg::RND_W-1:0]     random_value;
	logic [rbat_pkg::SEG_W-1:0]     segment_index;
	logic [rbat_pkg::ADDR_W-1:0]    block_address;

	modport source(output valid, command, random_value, segment_index, block_address,
		input ready);
	modport sink(input valid, command, random_value, segment_index, block_address,
		output ready);
endinterface

/* src/rbat_rsp_if.sv */
// rbat_rsp_if: result channel (valid/ready plus result fields).
// Depends on rbat_pkg.
interface rbat_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [rbat_pkg::ST_W-1:0]      status;
	logic [rbat_pkg::ADDR_W-1:0]    result_address;
	logic [rbat_pkg::CNT_W-1:0]     entry_count;

	modport source(output valid, status, result_address, entry_count, input ready);
	modport sink(input valid, status, result_address, entry_count, output ready);
endinterface

/* src/rbat_cfg_if.sv */
// rbat_cfg_if: configuration write channel (register index and data).
// Depends on rbat_pkg.
interface rbat_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rbat_pkg::CFG_IDX_W-1:0]    index;
	logic [rbat_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/rbat_arith.sv */
// rbat_arith: shared iterative unit, restoring divide (one quotient bit per
// cycle) and shift-add multiply (one multiplier bit per cycle). Uses rbat_pkg.
module rbat_arith (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            op,
	input  logic [rbat_pkg::WIDE_W-1:0]     opa,   // dividend / multiplier
	input  logic [rbat_pkg::ADDR_W-1:0]     opb,   // divisor / multiplicand
	output logic                            busy,
	output logic                            done,
	output logic [rbat_pkg::WIDE_W-1:0]     quo,   // quotient / product
	output logic [rbat_pkg::ADDR_W-1:0]     rem
);
	localparam int W  = rbat_pkg::WIDE_W;
	localparam int AW = rbat_pkg::ADDR_W;
	localparam int MW = rbat_pkg::SPB_W;
	localparam int CW = rbat_pkg::ARITH_CNT_W;

	logic          busy_q, done_q, op_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q, mcand_q;
	logic [AW-1:0] rem_q;
	logic [MW-1:0] mplier_q;
	logic [AW:0]   sh, diff;
	logic          ge;

	assign sh   = {rem_q, quo_q[W-1]};
	assign diff = sh - {1'b0, mcand_q[AW-1:0]};
	assign ge   = sh >= {1'b0, mcand_q[AW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (op == rbat_pkg::ARITH_DIV) ? CW'(W - 1) : CW'(MW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q     <= op;
			quo_q    <= (op == rbat_pkg::ARITH_DIV) ? opa : '0;
			rem_q    <= '0;
			mcand_q  <= {{(W-AW){1'b0}}, opb};
			mplier_q <= opa[MW-1:0];
		end else if (busy_q) begin
			if (op_q == rbat_pkg::ARITH_DIV) begin
				rem_q <= ge ? diff[AW-1:0] : sh[AW-1:0];
				quo_q <= {quo_q[W-2:0], ge};
			end else begin
				if (mplier_q[0])
					quo_q <= quo_q + mcand_q;
				mcand_q  <= {mcand_q[W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[MW-1:1]};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

/* src/rbat_datapath.sv */
// rbat_datapath: item and configuration registers, entry memory with linear
// search engine, arithmetic unit, result and output registers.
// Uses rbat_pkg, rbat_arith and the three channel interfaces.
module rbat_datapath #(
	parameter int TABLE_DEPTH = rbat_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	rbat_req_if.sink           req,
	rbat_rsp_if.source         rsp,
	rbat_cfg_if.sink           cfg,
	input  rbat_pkg::dp_cmd_t  cmd,
	output rbat_pkg::dp_stat_t st
);
	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int SA  = rbat_pkg::ADDR_W;
	localparam int W   = rbat_pkg::WIDE_W;

	// configuration
	logic [SA-1:0]                 dev_q, ss_q;
	logic [rbat_pkg::SPB_W-1:0]    spb_q;
	logic                          whole_q;
	logic                          cfg_wr;

	// captured item
	logic [rbat_pkg::CMD_W-1:0]    cmd_q;
	logic [rbat_pkg::RND_W-1:0]    rnd_q;
	logic [rbat_pkg::SEG_W-1:0]    seg_q;
	logic [SA-1:0]                 baddr_q;

	// allocate working registers
	logic [SA-1:0]                 off_q;
	logic [W-1:0]                  base_q, sector_q;

	// table
	logic [SA:0]                   mem_q [TABLE_DEPTH];
	logic [SA:0]                   rd_q;
	logic [CW-1:0]                 ent_total_q, last_c;
	logic                          mem_we, mem_re;
	logic [AW-1:0]                 mem_wa, mem_ra;
	logic [SA:0]                   mem_wd;

	// search engine
	logic                          srch_act_q, srch_done_q, srch_found_q;
	logic                          pend_s1;
	logic [AW-1:0]                 idx_s1, slot_q;
	logic [CW-1:0]                 scan_q;
	logic [SA-1:0]                 key_q;
	logic                          srch_hit, srch_issue, srch_miss;

	// arithmetic
	logic                          ar_op, ar_busy, ar_done;
	logic [W-1:0]                  ar_opa, ar_quo;
	logic [SA-1:0]                 ar_opb, ar_rem, span;

	// result / output
	logic [rbat_pkg::ST_W-1:0]     res_st_q, out_st_q;
	logic [SA-1:0]                 res_addr_q, out_addr_q;
	logic [rbat_pkg::CNT_W-1:0]    out_cnt_q;
	logic                          out_valid_q;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign req.ready = cmd.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q   <= SA'(1);
			spb_q   <= rbat_pkg::SPB_W'(1);
			ss_q    <= SA'(1);
			whole_q <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg.index)
				rbat_pkg::REG_DEV_SECTORS: dev_q   <= cfg.data;
				rbat_pkg::REG_SPB:         spb_q   <= cfg.data[rbat_pkg::SPB_W-1:0];
				rbat_pkg::REG_SEG_SECTORS: ss_q    <= cfg.data;
				rbat_pkg::REG_WHOLE_MODE:  whole_q <= cfg.data[0];
				default:                   ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q   <= req.command;
			rnd_q   <= req.random_value;
			seg_q   <= req.segment_index;
			baddr_q <= req.block_address;
		end
		if (cmd.lat_off)
			off_q <= ar_quo[SA-1:0];
		if (cmd.zero_base)
			base_q <= '0;
		else if (cmd.lat_base)
			base_q <= ar_quo;
		if (cmd.calc_sector)
			sector_q <= base_q + W'(off_q);
	end

	// operand routing for the shared unit
	assign span = whole_q ? dev_q : ss_q;
	always_comb begin
		ar_op  = rbat_pkg::ARITH_DIV;
		ar_opa = '0;
		ar_opb = '0;
		case (cmd.ar_src)
			rbat_pkg::SRC_SPAN_N: begin
				ar_opa = W'(span);
				ar_opb = SA'(spb_q);
			end
			rbat_pkg::SRC_RND_DIV: begin
				ar_opa = W'(rnd_q);
				ar_opb = ar_quo[SA-1:0];
			end
			rbat_pkg::SRC_REM_N: begin
				ar_op  = rbat_pkg::ARITH_MUL;
				ar_opa = W'(spb_q);
				ar_opb = ar_rem;
			end
			rbat_pkg::SRC_SEG_SS: begin
				ar_op  = rbat_pkg::ARITH_MUL;
				ar_opa = W'(seg_q);
				ar_opb = ss_q;
			end
			rbat_pkg::SRC_RND_TOT: begin
				ar_opa = W'(rnd_q);
				ar_opb = SA'(ent_total_q);
			end
			default: ;
		endcase
	end

	rbat_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.ar_start),
		.op    (ar_op),
		.opa   (ar_opa),
		.opb   (ar_opb),
		.busy  (ar_busy),
		.done  (ar_done),
		.quo   (ar_quo),
		.rem   (ar_rem)
	);

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ent_total_q <= '0;
		else if (cfg_wr || cmd.clear_total)
			ent_total_q <= '0;
		else if (cmd.inc_total)
			ent_total_q <= ent_total_q + CW'(1);
		else if (cmd.dec_total)
			ent_total_q <= ent_total_q - CW'(1);
	end

	// search: read issued at scan_q, compared in the following cycle
	assign srch_hit   = pend_s1 && (rd_q[SA-1:0] == key_q);
	assign srch_issue = srch_act_q && !srch_hit && (scan_q < ent_total_q);
	assign srch_miss  = srch_act_q && !srch_hit && !pend_s1 && (scan_q >= ent_total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_act_q   <= 1'b0;
			srch_done_q  <= 1'b0;
			srch_found_q <= 1'b0;
			pend_s1      <= 1'b0;
			scan_q       <= '0;
		end else begin
			srch_done_q <= 1'b0;
			pend_s1     <= srch_issue;
			if (cmd.srch_start) begin
				srch_act_q   <= 1'b1;
				srch_found_q <= 1'b0;
				scan_q       <= '0;
				pend_s1      <= 1'b0;
			end else if (srch_hit && srch_act_q) begin
				srch_act_q   <= 1'b0;
				srch_done_q  <= 1'b1;
				srch_found_q <= 1'b1;
			end else if (srch_miss) begin
				srch_act_q  <= 1'b0;
				srch_done_q <= 1'b1;
			end else if (srch_issue) begin
				scan_q <= scan_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_start)
			key_q <= (cmd.srch_key_sel == rbat_pkg::KEY_SECTOR) ? sector_q[SA-1:0] : baddr_q;
		if (srch_issue)
			idx_s1 <= scan_q[AW-1:0];
		if (srch_hit && srch_act_q)
			slot_q <= idx_s1;
	end

	// memory ports
	assign last_c = ent_total_q - CW'(1);
	always_comb begin
		mem_we = cmd.mem_wr;
		mem_wa = slot_q;
		mem_wd = rd_q;
		case (cmd.mem_wr_sel)
			rbat_pkg::WR_NEW: begin
				mem_wa = ent_total_q[AW-1:0];
				mem_wd = {1'b0, sector_q[SA-1:0]};
			end
			rbat_pkg::WR_MARK: mem_wd = {1'b1, key_q};
			rbat_pkg::WR_MOVE: mem_wd = rd_q;
			default:           mem_we = 1'b0;
		endcase
		mem_re = srch_issue || cmd.mem_rd;
		if (srch_issue)
			mem_ra = scan_q[AW-1:0];
		else if (cmd.mem_rd_sel == rbat_pkg::RD_LAST)
			mem_ra = last_c[AW-1:0];
		else
			mem_ra = ar_rem[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem_q[mem_ra];
	end

	// result and output registers
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_st_q <= cmd.res_st;
			case (cmd.res_addr_sel)
				rbat_pkg::RA_SECTOR: res_addr_q <= sector_q[SA-1:0];
				rbat_pkg::RA_RDDATA: res_addr_q <= rd_q[SA-1:0];
				default:             res_addr_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_st_q   <= res_st_q;
			out_addr_q <= res_addr_q;
			out_cnt_q  <= rbat_pkg::CNT_W'(ent_total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_st_q;
	assign rsp.result_address = out_addr_q;
	assign rsp.entry_count    = out_cnt_q;

	// status to controller
	always_comb begin
		st              = '0;
		st.req_valid    = req.valid;
		st.cmd_code     = cmd_q;
		st.n_zero       = (spb_q == '0);
		st.total_zero   = (ent_total_q == '0);
		st.total_full   = (ent_total_q >= CW'(TABLE_DEPTH));
		st.whole_mode   = whole_q;
		st.ar_done      = ar_done;
		st.quo_zero     = (ar_quo == '0);
		// segment bound reduces to off + n > segment size
		st.range_fail   = (!whole_q && (({1'b0, off_q} + (SA+1)'(spb_q)) > {1'b0, ss_q}))
			|| (({1'b0, sector_q} + (W+1)'(spb_q)) > (W+1)'(dev_q));
		st.srch_done    = srch_done_q;
		st.srch_found   = srch_found_q;
		st.rd_ready_bit = rd_q[SA];
		st.out_busy     = out_valid_q && !rsp.ready;
	end

`ifndef NO_ASSERTIONS
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.inc_total |-> (ent_total_q < CW'(TABLE_DEPTH)))
		else $error("entry added to a full table");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_total |-> (ent_total_q != '0))
		else $error("entry removed from an empty table");
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(srch_done_q && srch_found_q) |-> (CW'(slot_q) < ent_total_q))
		else $error("search hit beyond the table fill");
	a_arith_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ar_start |-> !ar_busy)
		else $error("arithmetic unit restarted while busy");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !rsp.ready))
		else $error("result overwritten before transfer");
`endif
endmodule

/* src/rbat_ctrl.sv */
// rbat_ctrl: controller state machine sequencing every operation through the
// datapath. Uses rbat_pkg command/status structs.
module rbat_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  rbat_pkg::dp_stat_t st,
	output rbat_pkg::dp_cmd_t  cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_ADIV1 = 4'd2;
	localparam logic [3:0] S_ADIV2 = 4'd3;
	localparam logic [3:0] S_AMUL1 = 4'd4;
	localparam logic [3:0] S_AMUL2 = 4'd5;
	localparam logic [3:0] S_ASUM  = 4'd6;
	localparam logic [3:0] S_ACHK  = 4'd7;
	localparam logic [3:0] S_ASRCH = 4'd8;
	localparam logic [3:0] S_SRCH  = 4'd9;
	localparam logic [3:0] S_RWR   = 4'd10;
	localparam logic [3:0] S_PDIV  = 4'd11;
	localparam logic [3:0] S_PCHK  = 4'd12;
	localparam logic [3:0] S_FIN   = 4'd13;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.req_valid)
					state_d = S_DISP;
			end
			S_DISP: begin
				state_d = S_FIN;
				cmd.set_res = 1'b1;
				cmd.res_st  = rbat_pkg::ST_OK;
				case (st.cmd_code)
					rbat_pkg::CMD_ALLOC: begin
						if (st.n_zero) begin
							cmd.res_st = rbat_pkg::ST_RANGE;
						end else begin
							cmd.set_res  = 1'b0;
							cmd.ar_start = 1'b1;
							cmd.ar_src   = rbat_pkg::SRC_SPAN_N;
							state_d      = S_ADIV1;
						end
					end
					rbat_pkg::CMD_REMOVE, rbat_pkg::CMD_MARK: begin
						cmd.set_res      = 1'b0;
						cmd.srch_start   = 1'b1;
						cmd.srch_key_sel = rbat_pkg::KEY_BADDR;
						state_d          = S_SRCH;
					end
					rbat_pkg::CMD_PICK: begin
						if (st.total_zero) begin
							cmd.res_st = rbat_pkg::ST_EMPTY;
						end else begin
							cmd.set_res  = 1'b0;
							cmd.ar_start = 1'b1;
							cmd.ar_src   = rbat_pkg::SRC_RND_TOT;
							state_d      = S_PDIV;
						end
					end
					rbat_pkg::CMD_CLEAR: cmd.clear_total = 1'b1;
					default:             cmd.res_st = rbat_pkg::ST_RANGE;
				endcase
			end
			S_ADIV1: begin
				if (st.ar_done) begin
					if (st.quo_zero) begin
						cmd.set_res = 1'b1;
						cmd.res_st  = rbat_pkg::ST_RANGE;
						state_d     = S_FIN;
					end else begin
						cmd.ar_start = 1'b1;
						cmd.ar_src   = rbat_pkg::SRC_RND_DIV;
						state_d      = S_ADIV2;
					end
				end
			end
			S_ADIV2: begin
				if (st.ar_done) begin
					cmd.ar_start = 1'b1;
					cmd.ar_src   = rbat_pkg::SRC_REM_N;
					state_d      = S_AMUL1;
				end
			end
			S_AMUL1: begin
				if (st.ar_done) begin
					cmd.lat_off = 1'b1;
					if (st.whole_mode) begin
						cmd.zero_base = 1'b1;
						state_d       = S_ASUM;
					end else begin
						cmd.ar_start = 1'b1;
						cmd.ar_src   = rbat_pkg::SRC_SEG_SS;
						state_d      = S_AMUL2;
					end
				end
			end
			S_AMUL2: begin
				if (st.ar_done) begin
					cmd.lat_base = 1'b1;
					state_d      = S_ASUM;
				end
			end
			S_ASUM: begin
				cmd.calc_sector = 1'b1;
				state_d         = S_ACHK;
			end
			S_ACHK: begin
				if (st.range_fail) begin
					cmd.set_res = 1'b1;
					cmd.res_st  = rbat_pkg::ST_RANGE;
					state_d     = S_FIN;
				end else begin
					cmd.srch_start   = 1'b1;
					cmd.srch_key_sel = rbat_pkg::KEY_SECTOR;
					state_d          = S_ASRCH;
				end
			end
			S_ASRCH: begin
				if (st.srch_done) begin
					cmd.set_res = 1'b1;
					state_d     = S_FIN;
					if (st.srch_found) begin
						cmd.res_st = rbat_pkg::ST_OCCUPIED;
					end else if (st.total_full) begin
						cmd.res_st = rbat_pkg::ST_FULL;
					end else begin
						cmd.res_st       = rbat_pkg::ST_OK;
						cmd.res_addr_sel = rbat_pkg::RA_SECTOR;
						cmd.mem_wr       = 1'b1;
						cmd.mem_wr_sel   = rbat_pkg::WR_NEW;
						cmd.inc_total    = 1'b1;
					end
				end
			end
			S_SRCH: begin
				if (st.srch_done) begin
					if (!st.srch_found) begin
						cmd.set_res = 1'b1;
						cmd.res_st  = rbat_pkg::ST_NOTFOUND;
						state_d     = S_FIN;
					end else if (st.cmd_code == rbat_pkg::CMD_MARK) begin
						cmd.mem_wr     = 1'b1;
						cmd.mem_wr_sel = rbat_pkg::WR_MARK;
						cmd.set_res    = 1'b1;
						cmd.res_st     = rbat_pkg::ST_OK;
						state_d        = S_FIN;
					end else begin
						cmd.mem_rd     = 1'b1;
						cmd.mem_rd_sel = rbat_pkg::RD_LAST;
						state_d        = S_RWR;
					end
				end
			end
			S_RWR: begin
				cmd.mem_wr     = 1'b1;
				cmd.mem_wr_sel = rbat_pkg::WR_MOVE;
				cmd.dec_total  = 1'b1;
				cmd.set_res    = 1'b1;
				cmd.res_st     = rbat_pkg::ST_OK;
				state_d        = S_FIN;
			end
			S_PDIV: begin
				if (st.ar_done) begin
					cmd.mem_rd     = 1'b1;
					cmd.mem_rd_sel = rbat_pkg::RD_PICK;
					state_d        = S_PCHK;
				end
			end
			S_PCHK: begin
				cmd.set_res = 1'b1;
				if (st.rd_ready_bit) begin
					cmd.res_st       = rbat_pkg::ST_OK;
					cmd.res_addr_sel = rbat_pkg::RA_RDDATA;
				end else begin
					cmd.res_st = rbat_pkg::ST_NOTREADY;
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* src/random_block_allocator_table.sv */
// random_block_allocator_table: top level; controller plus datapath.
// Uses rbat_pkg, rbat_ctrl, rbat_datapath and the channel interfaces.
//
// Keeps a dense table of allocated block start sectors with a ready flag
// each. One request in, one result out, one request in flight at a time;
// a new request is taken as soon as the controller is back in idle, even
// while the previous result still waits in the output register. Allocate
// runs two 64-step divides and one 17-step multiply on the shared iterative
// arithmetic unit in whole-device mode, then the duplicate search; segment
// mode adds a second 17-step multiply for the segment base. Remove and mark
// are bound by the linear search that reads the entry memory one word per
// cycle; pick is bound by the divide; clear and unknown commands go from
// dispatch straight to the result. The entry memory is never cleared: only
// entries below the fill count are read. Any configuration write empties
// the table; configuration is accepted every cycle (ready held high) and
// must only be written while no request is outstanding.
module random_block_allocator_table #(
	parameter int TABLE_DEPTH = rbat_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rbat_req_if.sink    req,
	rbat_rsp_if.source  rsp,
	rbat_cfg_if.sink    cfg
);
	rbat_pkg::dp_cmd_t  cmd;
	rbat_pkg::dp_stat_t st;

	// sequencing: idle -> dispatch -> arithmetic / search -> update -> result
	rbat_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.cmd   (cmd)
	);

	// storage, search engine, divider/multiplier and output register
	rbat_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg),
		.cmd   (cmd),
		.st    (st)
	);
endmodule

/* tb/sv/random_block_allocator_table_tb.sv */
`timescale 1ns / 1ps
// random_block_allocator_table_tb: self-checking bench for the block allocator table.
// Needs rbat_pkg, the three channel interfaces and random_block_allocator_table.
module random_block_allocator_table_tb;

	// Predicted result of one operation.
	typedef struct packed {
		logic [rbat_pkg::ST_W-1:0]   status;
		logic [rbat_pkg::ADDR_W-1:0] addr;
		logic [rbat_pkg::CNT_W-1:0]  count;
	} table_result_t;

	// Keeps a shadow copy of the table and the queue of predicted results.
	class table_scoreboard_t;
		logic [63:0]                 dev_sectors;
		logic [63:0]                 spb;
		logic [63:0]                 seg_sectors;
		bit                          whole_mode;
		logic [rbat_pkg::ADDR_W-1:0] slots[rbat_pkg::TABLE_DEPTH_DEF];
		bit                          slot_ready[rbat_pkg::TABLE_DEPTH_DEF];
		int                          fill;
		table_result_t               pending[$];
		int                          errors;

		function new();
			dev_sectors = 1;
			spb = 1;
			seg_sectors = 1;
			whole_mode = 1;
			fill = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [rbat_pkg::CFG_IDX_W-1:0] idx,
				logic [rbat_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				rbat_pkg::REG_DEV_SECTORS: dev_sectors = {16'd0, val};
				rbat_pkg::REG_SPB:         spb = {47'd0, val[rbat_pkg::SPB_W-1:0]};
				rbat_pkg::REG_SEG_SECTORS: seg_sectors = {16'd0, val};
				default:                   whole_mode = val[0];
			endcase
			fill = 0;
		endfunction

		function int find_slot(logic [rbat_pkg::ADDR_W-1:0] a);
			for (int i = 0; i < fill; i++)
				if (slots[i] == a)
					return i;
			return -1;
		endfunction

		function table_result_t place_block(logic [62:0] rnd, logic [15:0] seg);
			table_result_t r;
			logic [63:0] span, quo, sector;
			r = '0;
			span = whole_mode ? dev_sectors : seg_sectors;
			r.status = rbat_pkg::ST_RANGE;
			if (spb == 0)
				return r;
			quo = span / spb;
			if (quo == 0)
				return r;
			sector = ({1'b0, rnd} % quo) * spb;
			if (!whole_mode) begin
				sector += {48'd0, seg} * seg_sectors;
				if (sector + spb > ({48'd0, seg} + 64'd1) * seg_sectors)
					return r;
			end
			if (sector + spb > dev_sectors)
				return r;
			if (find_slot(sector[rbat_pkg::ADDR_W-1:0]) >= 0)
				r.status = rbat_pkg::ST_OCCUPIED;
			else if (fill >= rbat_pkg::TABLE_DEPTH_DEF)
				r.status = rbat_pkg::ST_FULL;
			else begin
				slots[fill] = sector[rbat_pkg::ADDR_W-1:0];
				slot_ready[fill] = 0;
				fill++;
				r.status = rbat_pkg::ST_OK;
				r.addr = sector[rbat_pkg::ADDR_W-1:0];
			end
			return r;
		endfunction

		// Accepted request: update the shadow table and queue the result.
		function void note_request(logic [rbat_pkg::CMD_W-1:0] cmd, logic [62:0] rnd,
				logic [15:0] seg, logic [rbat_pkg::ADDR_W-1:0] baddr);
			table_result_t r;
			int s;
			r = '0;
			r.status = rbat_pkg::ST_OK;
			case (cmd)
				rbat_pkg::CMD_ALLOC: r = place_block(rnd, seg);
				rbat_pkg::CMD_REMOVE: begin
					s = find_slot(baddr);
					if (s < 0)
						r.status = rbat_pkg::ST_NOTFOUND;
					else begin
						slots[s] = slots[fill-1];
						slot_ready[s] = slot_ready[fill-1];
						fill--;
					end
				end
				rbat_pkg::CMD_PICK: begin
					if (fill == 0)
						r.status = rbat_pkg::ST_EMPTY;
					else begin
						s = int'({1'b0, rnd} % 64'(fill));
						if (slot_ready[s])
							r.addr = slots[s];
						else
							r.status = rbat_pkg::ST_NOTREADY;
					end
				end
				rbat_pkg::CMD_MARK: begin
					s = find_slot(baddr);
					if (s < 0)
						r.status = rbat_pkg::ST_NOTFOUND;
					else
						slot_ready[s] = 1;
				end
				rbat_pkg::CMD_CLEAR: fill = 0;
				default: r.status = rbat_pkg::ST_RANGE;
			endcase
			r.count = rbat_pkg::CNT_W'(fill);
			pending.push_back(r);
		endfunction

		function void check_result(table_result_t got);
			table_result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result st=%0d addr=%h cnt=%0d", $time,
					got.status, got.addr, got.count);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
				errors++;
			end
			if (got.addr !== exp.addr) begin
				$display("%0t: address exp %h got %h", $time, exp.addr, got.addr);
				errors++;
			end
			if (got.count !== exp.count) begin
				$display("%0t: count exp %0d got %0d", $time, exp.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rbat_req_if req ();
	rbat_rsp_if rsp ();
	rbat_cfg_if cfg ();

	random_block_allocator_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	table_scoreboard_t sb = new();
	bit quiet;        // last stretch of the run: no idling on either side
	int idle_cycles;  // watchdog: cycles with no transfer on any channel
	logic [rbat_pkg::ADDR_W-1:0] known_addrs[$];  // addresses handed out, reused for remove/mark

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	// Sink side: random stalls in bursts, checks each transfer.
	initial begin
		int stall;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				sb.check_result({rsp.status, rsp.result_address, rsp.entry_count});
				if (rsp.status == rbat_pkg::ST_OK && rsp.result_address != 0)
					known_addrs.push_back(rsp.result_address);
				if (known_addrs.size() > 64)
					void'(known_addrs.pop_front());
			end
			if (stall > 0) begin
				stall--;
				rsp.ready <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 4);
				rsp.ready <= 0;
			end else
				rsp.ready <= 1;
		end
	end

	// Watchdog: a long stretch with no transfer means the block has hung.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
					|| (cfg.valid && cfg.ready))
				idle_cycles = 0;
			else if (++idle_cycles > 20000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Valid stays high after a transfer until the next request, an idle gap or a
	// drain lowers it; the block takes nothing new before it is back in idle.
	task automatic send_op(logic [rbat_pkg::CMD_W-1:0] cmd, logic [62:0] rnd,
			logic [15:0] seg, logic [rbat_pkg::ADDR_W-1:0] baddr);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req.valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req.valid <= 1;
		req.command <= cmd;
		req.random_value <= rnd;
		req.segment_index <= seg;
		req.block_address <= baddr;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_request(cmd, rnd, seg, baddr);
	endtask

	// Waits for every outstanding result with the request side idle.
	task automatic wait_results();
		req.valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic drain();
		wait_results();
		repeat (400) @(posedge clk);
	endtask

	// Registers may only change with nothing in flight.
	task automatic write_reg(logic [rbat_pkg::CFG_IDX_W-1:0] idx,
			logic [rbat_pkg::CFG_DATA_W-1:0] val);
		drain();
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		sb.write_reg(idx, val);
		cfg.valid <= 0;
		known_addrs.delete();
	endtask

	function automatic logic [62:0] rand63();
		return 63'({$urandom(), $urandom()});
	endfunction

	function automatic logic [rbat_pkg::ADDR_W-1:0] rand48();
		return rbat_pkg::ADDR_W'({$urandom(), $urandom()});
	endfunction

	// Mostly well-formed traffic: allocate often, remove/mark known addresses.
	task automatic random_ops(int n, bit fill_up);
		int pick;
		logic [rbat_pkg::ADDR_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			a = known_addrs.size() ? known_addrs[$urandom_range(0, known_addrs.size()-1)]
				: rand48();
			if ($urandom_range(0, 9) == 0)
				a = rand48();
			if (pick < (fill_up ? 80 : 40))
				send_op(rbat_pkg::CMD_ALLOC, rand63(),
					$urandom_range(0, 3) == 0 ? 16'($urandom())
					: 16'($urandom_range(0, 7)), rand48());
			else if (pick < 60)
				send_op(rbat_pkg::CMD_MARK, rand63(), 16'($urandom()), a);
			else if (pick < 78)
				send_op(rbat_pkg::CMD_PICK, rand63(), 16'($urandom()), rand48());
			else if (pick < 95)
				send_op(rbat_pkg::CMD_REMOVE, rand63(), 16'($urandom()), a);
			else if (pick < 98)
				send_op(rbat_pkg::CMD_CLEAR, rand63(), 16'($urandom()), rand48());
			else
				send_op(rbat_pkg::CMD_W'($urandom_range(5, 7)), rand63(),
					16'($urandom()), rand48());
		end
	endtask

	initial begin
		quiet = 0;
		req.valid = 0;
		req.command = rbat_pkg::CMD_CLEAR;
		req.random_value = '0;
		req.segment_index = '0;
		req.block_address = '0;
		cfg.valid = 0;
		cfg.index = rbat_pkg::REG_DEV_SECTORS;
		cfg.data = '0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed: reset config gives a one-sector device.
		send_op(rbat_pkg::CMD_PICK, '0, '0, '0);          // empty table
		send_op(rbat_pkg::CMD_ALLOC, '1, '1, '0);         // sector 0
		send_op(rbat_pkg::CMD_ALLOC, '0, '0, '0);         // occupied
		send_op(rbat_pkg::CMD_PICK, '1, '0, '0);          // not ready
		send_op(rbat_pkg::CMD_MARK, '0, '0, '1);          // not found
		send_op(rbat_pkg::CMD_MARK, '0, '0, '0);
		send_op(rbat_pkg::CMD_PICK, 63'd5, '0, '0);       // picks sector 0
		send_op(rbat_pkg::CMD_REMOVE, '0, '0, 48'd7);     // not found
		send_op(rbat_pkg::CMD_REMOVE, '0, '0, '0);
		send_op(3'd5, '1, '1, '1);                        // unknown commands
		send_op(3'd7, '0, '0, '0);
		send_op(rbat_pkg::CMD_CLEAR, '0, '0, '0);

		// Zero divisor, then block larger than span.
		write_reg(rbat_pkg::REG_SPB, 48'd0);
		send_op(rbat_pkg::CMD_ALLOC, rand63(), '0, '0);
		write_reg(rbat_pkg::REG_SPB, 48'h1FFFF);          // largest field value
		send_op(rbat_pkg::CMD_ALLOC, rand63(), '0, '0);
		write_reg(rbat_pkg::REG_DEV_SECTORS, '1);
		send_op(rbat_pkg::CMD_ALLOC, '1, '0, '0);
		send_op(rbat_pkg::CMD_ALLOC, '0, '0, '0);

		// Segment mode with a segment bound that is not block-aligned.
		write_reg(rbat_pkg::REG_WHOLE_MODE, 48'd0);
		write_reg(rbat_pkg::REG_SPB, 48'd4);
		write_reg(rbat_pkg::REG_SEG_SECTORS, 48'd10);
		write_reg(rbat_pkg::REG_DEV_SECTORS, 48'd45);
		send_op(rbat_pkg::CMD_ALLOC, 63'd2, 16'd0, '0);   // sector 0
		send_op(rbat_pkg::CMD_ALLOC, 63'd1, 16'd3, '0);   // 34
		send_op(rbat_pkg::CMD_ALLOC, 63'd1, 16'd4, '0);   // 44+4 > 45: out of device
		send_op(rbat_pkg::CMD_ALLOC, '0, 16'hFFFF, '0);
		write_reg(rbat_pkg::REG_SEG_SECTORS, '1);
		send_op(rbat_pkg::CMD_ALLOC, '1, 16'd0, '0);

		// Random phases over several settings.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(rbat_pkg::REG_WHOLE_MODE, 48'd1);
					write_reg(rbat_pkg::REG_SPB, 48'd1);
					write_reg(rbat_pkg::REG_DEV_SECTORS, 48'd300);  // small device: table fills
				end
				1: begin
					write_reg(rbat_pkg::REG_SPB, 48'd1);
					write_reg(rbat_pkg::REG_DEV_SECTORS, 48'd40);   // many collisions
				end
				2: begin
					write_reg(rbat_pkg::REG_SPB, 48'h10000);
					write_reg(rbat_pkg::REG_DEV_SECTORS, '1);
				end
				3: begin
					write_reg(rbat_pkg::REG_WHOLE_MODE, 48'd0);
					write_reg(rbat_pkg::REG_SPB, 48'd3);
					write_reg(rbat_pkg::REG_SEG_SECTORS, 48'd20);
					write_reg(rbat_pkg::REG_DEV_SECTORS, 48'd150);
				end
				4: begin
					write_reg(rbat_pkg::REG_SPB, 48'd8);
					write_reg(rbat_pkg::REG_SEG_SECTORS, 48'h0000_8000_0001);
					write_reg(rbat_pkg::REG_DEV_SECTORS, '1);
				end
				5: begin
					write_reg(rbat_pkg::REG_SEG_SECTORS, '1);
					write_reg(rbat_pkg::REG_SPB, 48'd1);
				end
				6: begin
					write_reg(rbat_pkg::REG_WHOLE_MODE, 48'd1);
					write_reg(rbat_pkg::REG_SPB, 48'($urandom_range(1, 70000)));
					write_reg(rbat_pkg::REG_DEV_SECTORS, rand48());
				end
				default: begin
					write_reg(rbat_pkg::REG_SPB, 48'd2);
					write_reg(rbat_pkg::REG_DEV_SECTORS, 48'd1000);
					quiet = 1;
				end
			endcase
			random_ops(ph == 0 ? 400 : 160, ph == 0);
			if (ph == 3) begin
				// hold off until every result is back, then go on
				wait_results();
			end
		end

		drain();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
